@@ sv/srdz_pkg.sv @@
// Shared types and constants for the stick radial dead zone block.
// No dependencies; imported by every module of the block.
`default_nettype none
package srdz_pkg;

  localparam int unsigned SQRT_BITS = 31;  // root of magnitude^2 * 2^30
  localparam int unsigned QUO_BITS  = 15;  // mid-range radius quotient
  // r1 + root stages (incl. setup) + divider stages (incl. setup) + select
  localparam int unsigned RAD_LAT   = 1 + (SQRT_BITS + 1) + (QUO_BITS + 1) + 1;

  localparam logic [15:0] FULL_SCALE   = 16'h8000;
  localparam logic [15:0] INNER_RESET  = 16'd9600;
  localparam logic [15:0] OUTER_RESET  = 16'd31232;

  localparam logic [7:0] CFG_INNER = 8'd0;
  localparam logic [7:0] CFG_OUTER = 8'd1;

  localparam int unsigned ATAN_LEN = 24;
  localparam logic [31:0] ATAN_TABLE [0:ATAN_LEN-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic [15:0]        radius;
    logic signed [15:0] angle;
  } lane_res_t;

endpackage
`default_nettype wire

@@ sv/srdz_cordic.sv @@
// Pipelined vectoring rotator: one micro-rotation per stage, binary angle out.
// Depends on srdz_pkg (arctangent table).
`default_nettype none
module srdz_cordic import srdz_pkg::*; #(
  parameter int unsigned ITERS = 16
) (
  input  wire logic               clk_i,
  input  wire logic signed [15:0] x_i,
  input  wire logic signed [15:0] y_i,
  output logic signed [15:0]      angle_o
);

  logic signed [31:0] x_q [0:ITERS];
  logic signed [31:0] y_q [0:ITERS];
  logic [31:0]        z_q [0:ITERS];
  logic               zero_q [0:ITERS];
  logic [31:0]        rnd;

  // fold the left half plane onto the right one, then scale up
  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == 16'sd0) && (y_i == 16'sd0);
    if (x_i[15]) begin
      x_q[0] <= (-32'(x_i)) <<< 14;
      y_q[0] <= (-32'(y_i)) <<< 14;
      z_q[0] <= 32'h80000000;
    end else begin
      x_q[0] <= 32'(x_i) <<< 14;
      y_q[0] <= 32'(y_i) <<< 14;
      z_q[0] <= 32'h0;
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      if (!y_q[i][31]) begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + ATAN_TABLE[i];
      end else begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - ATAN_TABLE[i];
      end
    end
  end

  assign rnd = z_q[ITERS] + 32'h00008000;

  always_ff @(posedge clk_i) begin
    angle_o <= zero_q[ITERS] ? 16'sd0 : $signed(rnd[31:16]);
  end

endmodule
`default_nettype wire

@@ sv/srdz_radius.sv @@
// Radial dead zone: squares, bit-per-stage square root, bit-per-stage divide.
// Depends on srdz_pkg (stage counts, full scale).
`default_nettype none
module srdz_radius import srdz_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic signed [15:0] x_i,
  input  wire logic signed [15:0] y_i,
  input  wire logic [15:0]        inner_i,
  input  wire logic [15:0]        outer_i,
  output logic [15:0]             radius_o
);

  logic [15:0] ax, ay;
  logic [31:0] ax2_q, ay2_q, in2_q, out2_q;
  logic [15:0] in1_q, d1_q;
  logic [31:0] sq;

  assign ax = x_i[15] ? 16'(-x_i) : 16'(x_i);
  assign ay = y_i[15] ? 16'(-y_i) : 16'(y_i);

  always_ff @(posedge clk_i) begin
    ax2_q  <= ax * ax;
    ay2_q  <= ay * ay;
    in2_q  <= inner_i * inner_i;
    out2_q <= outer_i * outer_i;
    in1_q  <= inner_i;
    d1_q   <= outer_i - inner_i;
  end

  assign sq = ax2_q + ay2_q;

  // root stages: index 0 is the setup register
  logic [63:0]          rem_q  [0:SQRT_BITS];
  logic [SQRT_BITS-1:0] root_q [0:SQRT_BITS];
  logic                 zs_q   [0:SQRT_BITS];
  logic                 fs_q   [0:SQRT_BITS];
  logic [15:0]          ins_q  [0:SQRT_BITS];
  logic [15:0]          ds_q   [0:SQRT_BITS];

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= {2'b00, sq, 30'b0};
    root_q[0] <= '0;
    zs_q[0]   <= sq <= in2_q;
    fs_q[0]   <= sq >= out2_q;
    ins_q[0]  <= in1_q;
    ds_q[0]   <= d1_q;
  end

  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
    localparam int unsigned B = SQRT_BITS - 1 - k;
    logic [63:0] trial;
    assign trial = (64'(root_q[k]) << (B + 1)) + (64'd1 << (2 * B));
    always_ff @(posedge clk_i) begin
      zs_q[k+1]  <= zs_q[k];
      fs_q[k+1]  <= fs_q[k];
      ins_q[k+1] <= ins_q[k];
      ds_q[k+1]  <= ds_q[k];
      if (rem_q[k] >= trial) begin
        rem_q[k+1]  <= rem_q[k] - trial;
        root_q[k+1] <= root_q[k] | (SQRT_BITS'(1) << B);
      end else begin
        rem_q[k+1]  <= rem_q[k];
        root_q[k+1] <= root_q[k];
      end
    end
  end

  // divider stages: index 0 holds the numerator
  logic [SQRT_BITS-1:0] num_q [0:QUO_BITS];
  logic [QUO_BITS-1:0]  quo_q [0:QUO_BITS];
  logic                 zd_q  [0:QUO_BITS];
  logic                 fd_q  [0:QUO_BITS];
  logic [15:0]          dd_q  [0:QUO_BITS];

  always_ff @(posedge clk_i) begin
    num_q[0] <= root_q[SQRT_BITS] - {ins_q[SQRT_BITS], 15'b0};
    quo_q[0] <= '0;
    zd_q[0]  <= zs_q[SQRT_BITS];
    fd_q[0]  <= fs_q[SQRT_BITS];
    dd_q[0]  <= ds_q[SQRT_BITS];
  end

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    localparam int unsigned B = QUO_BITS - 1 - j;
    logic [SQRT_BITS-1:0] dsh;
    assign dsh = SQRT_BITS'(dd_q[j]) << B;
    always_ff @(posedge clk_i) begin
      zd_q[j+1] <= zd_q[j];
      fd_q[j+1] <= fd_q[j];
      dd_q[j+1] <= dd_q[j];
      if (num_q[j] >= dsh) begin
        num_q[j+1] <= num_q[j] - dsh;
        quo_q[j+1] <= quo_q[j] | (QUO_BITS'(1) << B);
      end else begin
        num_q[j+1] <= num_q[j];
        quo_q[j+1] <= quo_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (zd_q[QUO_BITS])      radius_o <= 16'd0;
    else if (fd_q[QUO_BITS]) radius_o <= FULL_SCALE;
    else                     radius_o <= 16'(quo_q[QUO_BITS]);
  end

endmodule
`default_nettype wire

@@ sv/srdz_lane.sv @@
// One stick lane: radius pipeline beside the angle pipeline, angle delayed to match.
// Depends on srdz_pkg, srdz_cordic, srdz_radius.
`default_nettype none
module srdz_lane import srdz_pkg::*; #(
  parameter int unsigned ITERS = 16
) (
  input  wire logic               clk_i,
  input  wire logic signed [15:0] x_i,
  input  wire logic signed [15:0] y_i,
  input  wire logic [15:0]        inner_i,
  input  wire logic [15:0]        outer_i,
  output lane_res_t               res_o
);

  localparam int unsigned PAD = RAD_LAT - (ITERS + 2);

  logic signed [15:0] ang;
  logic signed [15:0] pad_q [0:PAD-1];

  srdz_cordic #(.ITERS(ITERS)) u_cordic (
    .clk_i, .x_i, .y_i, .angle_o(ang)
  );

  srdz_radius u_radius (
    .clk_i, .x_i, .y_i, .inner_i, .outer_i, .radius_o(res_o.radius)
  );

  always_ff @(posedge clk_i) begin
    pad_q[0] <= ang;
  end

  for (genvar p = 1; p < PAD; p++) begin : g_pad
    always_ff @(posedge clk_i) begin
      pad_q[p] <= pad_q[p-1];
    end
  end

  assign res_o.angle = pad_q[PAD-1];

endmodule
`default_nettype wire

@@ sv/stick_radial_dead_zone_polar_top.sv @@
// Top level: two stick lanes, configuration registers, result strobe and merge.
// Depends on srdz_pkg and srdz_lane.
`default_nettype none
// Each poll of both sticks is taken on any cycle with start high (busy never
// rises), one poll per cycle, and its word comes back on the result ports
// with done_o high for exactly one cycle (the squaring register loads on the
// accepting edge itself). Each poll passes the radius path: a squaring
// register, a setup register and a 31-stage square root that settles one root
// bit per stage, a setup register and a 15-stage divider that settles one
// quotient bit per stage, and the dead-zone select; the angle rotator
// (ANGLE_ITERATIONS + 2 stages) is delayed to line up, and one merge register
// follows. The receiver cannot stall; results leave in the order polls arrived.
// Write the thresholds only while no poll is in flight.
module stick_radial_dead_zone_polar_top import srdz_pkg::*; #(
  parameter int unsigned ANGLE_ITERATIONS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] left_x_i,
  input  wire logic signed [15:0] left_y_i,
  input  wire logic signed [15:0] right_x_i,
  input  wire logic signed [15:0] right_y_i,
  output logic                    done_o,
  output logic [15:0]             left_radius_o,
  output logic signed [15:0]      left_angle_o,
  output logic [15:0]             right_radius_o,
  output logic signed [15:0]      right_angle_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  logic [15:0]        inner_q, outer_q;
  logic [RAD_LAT-1:0] vld_q;
  logic               done_q;
  lane_res_t          left_res, right_res, left_q, right_q;

  // pipeline never stalls
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // hold thresholds; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= INNER_RESET;
      outer_q <= OUTER_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_INNER) inner_q <= cfg_data_i;
      if (cfg_index_i == CFG_OUTER) outer_q <= cfg_data_i;
    end
  end

  srdz_lane #(.ITERS(ANGLE_ITERATIONS)) u_left (
    .clk_i, .x_i(left_x_i), .y_i(left_y_i),
    .inner_i(inner_q), .outer_i(outer_q), .res_o(left_res)
  );

  srdz_lane #(.ITERS(ANGLE_ITERATIONS)) u_right (
    .clk_i, .x_i(right_x_i), .y_i(right_y_i),
    .inner_i(inner_q), .outer_i(outer_q), .res_o(right_res)
  );

  // advance the word marker alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[RAD_LAT-2:0], start & ~busy};
      done_q <= vld_q[RAD_LAT-1];
    end
  end

  // merge both lanes into one result word
  always_ff @(posedge clk_i) begin
    left_q  <= left_res;
    right_q <= right_res;
  end

  assign done_o         = done_q;
  assign left_radius_o  = left_q.radius;
  assign left_angle_o   = left_q.angle;
  assign right_radius_o = right_q.radius;
  assign right_angle_o  = right_q.angle;

`ifndef ASSERT_OFF
  localparam int unsigned LAT = RAD_LAT + 1;

  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result strobe without a matching poll");

  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> left_radius_o <= FULL_SCALE)
    else $error("left radius above full scale");

  a_right_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> right_radius_o <= FULL_SCALE)
    else $error("right radius above full scale");
`endif

endmodule
`default_nettype wire

@@ test/stick_radial_dead_zone_polar_top_tb.sv @@
// Self-checking testbench for stick_radial_dead_zone_polar_top: directed and random polls
// under several dead-zone settings, checked against a built-in predictor of radius and angle.
// Depends on srdz_pkg and the block's RTL.
`default_nettype none
module stick_radial_dead_zone_polar_top_tb import srdz_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITERS = 16;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct {
    logic signed [15:0] lx, ly, rx, ry;
  } poll_t;

  typedef struct {
    logic [15:0]        l_rad;
    logic signed [15:0] l_ang;
    logic [15:0]        r_rad;
    logic signed [15:0] r_ang;
  } polar_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] left_x_i = '0, left_y_i = '0, right_x_i = '0, right_y_i = '0;
  logic done_o;
  logic [15:0] left_radius_o, right_radius_o;
  logic signed [15:0] left_angle_o, right_angle_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  stick_radial_dead_zone_polar_top #(.ANGLE_ITERATIONS(ITERS)) u_top (.*);

  always #5 clk_i = ~clk_i;

  // Predictor copy of the two threshold registers.
  logic [15:0] inner_thr = INNER_RESET;
  logic [15:0] outer_thr = OUTER_RESET;

  poll_t  pending_polls[$];
  polar_t expected_words[$];
  int     send_idle_pct = 0;
  bit     hold_send = 1'b1;
  int     n_errors = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     stall_cycles = 0;

  // Exact radial dead zone: the largest q with (q*d + inner*FS)^2 <= FS^2 * m^2.
  function automatic logic [15:0] dead_zone_radius(logic signed [15:0] x, logic signed [15:0] y);
    longint unsigned ax, ay, sq, inn, out, d, target, lo, hi, mid, lhs;
    ax = (x < 0) ? longint'(-longint'(x)) : longint'(x);
    ay = (y < 0) ? longint'(-longint'(y)) : longint'(y);
    sq = ax * ax + ay * ay;
    inn = inner_thr;
    out = outer_thr;
    if (sq <= inn * inn) return 16'd0;
    if (sq >= out * out) return FULL_SCALE;
    d = out - inn;
    target = 64'd1073741824 * sq;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = mid * d + inn * 32768;
      if (lhs * lhs <= target) lo = mid;
      else hi = mid - 1;
    end
    return (lo > 32768) ? FULL_SCALE : lo[15:0];
  endfunction

  // Vectoring rotation toward the positive x axis, 32-bit binary-angle accumulator.
  function automatic logic signed [15:0] vector_angle(logic signed [15:0] xi,
                                                      logic signed [15:0] yi);
    longint x, y, dx, dy;
    logic [31:0] z, zr;
    x = xi;
    y = yi;
    z = '0;
    if (x == 0 && y == 0) return 16'sd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    x = x * 16384;
    y = y * 16384;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_TABLE[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_TABLE[i];
      end
    end
    zr = z + 32'h8000;
    return zr[31:16];
  endfunction

  function automatic polar_t polar_of(poll_t p);
    polar_t r;
    r.l_rad = dead_zone_radius(p.lx, p.ly);
    r.l_ang = vector_angle(p.lx, p.ly);
    r.r_rad = dead_zone_radius(p.rx, p.ry);
    r.r_ang = vector_angle(p.rx, p.ry);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("MISMATCH word %0d %s: got %0d expected %0d", n_checked, what, got, want);
  endtask

  // Driver: on an accepted word, log its prediction and advance; then offer the next one.
  always @(posedge clk_i) begin
    if (start && !busy) begin
      expected_words.push_back(polar_of(pending_polls[0]));
      void'(pending_polls.pop_front());
      n_sent++;
    end
    if (!hold_send && pending_polls.size() > 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      start     <= 1'b1;
      left_x_i  <= pending_polls[0].lx;
      left_y_i  <= pending_polls[0].ly;
      right_x_i <= pending_polls[0].rx;
      right_y_i <= pending_polls[0].ry;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: every strobed word must match the oldest prediction.
  always @(posedge clk_i) begin
    if (done_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected strobe", 1, 0);
      end else begin
        polar_t w;
        w = expected_words.pop_front();
        if (left_radius_o !== w.l_rad) report_mismatch("left_radius", left_radius_o, w.l_rad);
        if (left_angle_o !== w.l_ang) report_mismatch("left_angle", left_angle_o, w.l_ang);
        if (right_radius_o !== w.r_rad)
          report_mismatch("right_radius", right_radius_o, w.r_rad);
        if (right_angle_o !== w.r_ang) report_mismatch("right_angle", right_angle_o, w.r_ang);
        n_checked++;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("stick_radial_dead_zone_polar_top test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    if (idx == CFG_INNER) inner_thr = val;
    else if (idx == CFG_OUTER) outer_thr = val;
  endtask

  task automatic add_poll(int lx, int ly, int rx, int ry);
    poll_t p;
    p.lx = lx;
    p.ly = ly;
    p.rx = rx;
    p.ry = ry;
    pending_polls.push_back(p);
  endtask

  function automatic int stick_coord(int thr);
    int k;
    k = $urandom_range(9);
    if (k < 4) return $signed(16'($urandom));           // anywhere
    if (k < 6) return $urandom_range(200) - 100;        // near center
    if (k == 6) return $urandom_range(1) ? 32767 : -32768;
    if (k == 7) return 0;                               // on an axis
    return (thr + $urandom_range(4) - 2) * ($urandom_range(1) ? 1 : -1);  // at a threshold
  endfunction

  // Queue random polls, hold off midway until the pipe drains, then drain at the end.
  task automatic run_phase(int n);
    int thr;
    for (int i = 0; i < n; i++) begin
      thr = $urandom_range(1) ? inner_thr : outer_thr;
      if (thr > 32767) thr = 32767;
      add_poll(stick_coord(thr), stick_coord(thr), stick_coord(thr), stick_coord(thr));
    end
    hold_send = 1'b0;
    wait (pending_polls.size() <= n / 2);
    hold_send = 1'b1;
    wait (expected_words.size() == 0 && !start);
    repeat ($urandom_range(5)) @(posedge clk_i);
    hold_send = 1'b0;
    wait (pending_polls.size() == 0);
    hold_send = 1'b1;
    wait (expected_words.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, centered stick, half turn, axes, exact thresholds.
    add_poll(0, 0, 0, 0);
    add_poll(-32768, 0, 32767, 0);
    add_poll(-1, 0, 0, -1);
    add_poll(-32768, -32768, 32767, 32767);
    add_poll(-32768, 32767, 32767, -32768);
    add_poll(0, 32767, 0, -32768);
    add_poll(9600, 0, 0, 9601);
    add_poll(31232, 0, -31231, 0);
    add_poll(5760, 7680, 5761, 7680);
    add_poll(20000, -20000, -1, 1);
    add_poll(1, 0, 0, 1);
    add_poll(-5, 3, 7, -2);
    send_idle_pct = 22;
    run_phase(0);

    // Random phases across settings, including both extremes and outer below inner.
    run_phase(80);
    write_reg(CFG_INNER, 16'd0);
    write_reg(CFG_OUTER, 16'd0);
    run_phase(50);
    write_reg(CFG_OUTER, 16'd46341);
    run_phase(60);
    send_idle_pct = 75;
    write_reg(CFG_INNER, 16'd46341);
    write_reg(8'd2, 16'd123);  // unmapped index: drop
    run_phase(50);
    write_reg(CFG_INNER, 16'd20000);
    write_reg(CFG_OUTER, 16'd10000);
    run_phase(60);
    write_reg(CFG_INNER, 16'hFFFF);
    write_reg(CFG_OUTER, 16'hFFFF);
    run_phase(40);
    send_idle_pct = 0;
    write_reg(CFG_INNER, 16'd100);
    write_reg(CFG_OUTER, 16'd32000);
    run_phase(90);
    write_reg(CFG_INNER, INNER_RESET);
    write_reg(CFG_OUTER, OUTER_RESET);
    run_phase(110);

    $display("Sent %0d polls, checked %0d words over eight threshold settings,", n_sent,
             n_checked);
    $display("with sender idling at 22, 75 and 0 percent; %0d mismatches.", n_errors);
    if (n_errors == 0 && expected_words.size() == 0)
      $display("stick_radial_dead_zone_polar_top test passed");
    else
      $display("stick_radial_dead_zone_polar_top test failed");
    $finish;
  end
endmodule
`default_nettype wire
